// ===== design/bsa_pkg.sv =====
// Shared constants, request codes and helper functions for the bitmap slab allocator.
package bsa_pkg;

  // Field widths fixed by the interface
  localparam int ADDR_W       = 32;
  localparam int SIZE_W       = 4;
  localparam int REQ_W        = 2;
  localparam int SEL_W        = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int CACHE_CNT_W  = 6;
  localparam int TOTAL_CNT_W  = 7;
  localparam int BYTES_W      = 19;

  // Default geometry
  localparam int SLOTS_PER_CACHE_DEF = 32;
  localparam int NUM_CACHES_DEF      = 3;

  // Object sizes above this saturate
  localparam logic [SIZE_W-1:0] MAX_SIZE_LOG2 = 4'd12;

  // Caches that have configuration registers
  localparam int NUM_CFG_CACHES = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FIRST = 3'd3;

  // Reset object sizes for the configurable caches
  localparam logic [SIZE_W-1:0] SIZE_RESET_SMALL  = 4'd5;
  localparam logic [SIZE_W-1:0] SIZE_RESET_MEDIUM = 4'd6;
  localparam logic [SIZE_W-1:0] SIZE_RESET_LARGE  = 4'd7;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  // Reset value of a cache's size register; caches without a register stay 0
  function automatic logic [SIZE_W-1:0] size_reset(input int cache);
    logic [SIZE_W-1:0] val;
    case (cache)
      0:       val = SIZE_RESET_SMALL;
      1:       val = SIZE_RESET_MEDIUM;
      2:       val = SIZE_RESET_LARGE;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Saturate log2 object size
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] sz);
    return (sz > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : sz;
  endfunction

endpackage

// ===== design/bsa_lowest_free.sv =====
// Priority encoder: index of the lowest set bit of a free-slot mask.
module bsa_lowest_free
  import bsa_pkg::*;
#(
  parameter int SLOTS_PER_CACHE = SLOTS_PER_CACHE_DEF,
  parameter int SLOT_W          = (SLOTS_PER_CACHE > 1) ? $clog2(SLOTS_PER_CACHE) : 1
) (
  input  logic [SLOTS_PER_CACHE-1:0] avail_bits,
  output logic                       found,
  output logic [SLOT_W-1:0]          index
);

  // Scan from the top so the lowest set bit wins
  always_comb begin
    index = '0;
    for (int i = SLOTS_PER_CACHE - 1; i >= 0; i--) begin
      if (avail_bits[i]) begin
        index = SLOT_W'(i);
      end
    end
  end

  assign found = |avail_bits;

endmodule

// ===== design/bitmap_slab_allocator.sv =====
// Top level of the bitmap slab allocator: request register, slot logic, result register.
//
//  Channel  Ports                          Direction  Transfer
//  in       in_valid/in_ready + fields      input      valid & ready at clk rise
//  out      out_valid/out_ready + fields    output     valid & ready at clk rise
//  cfg      cfg_wr_en/cfg_index/cfg_wdata   input      cfg_wr_en at clk rise
//
// One transaction per cycle sustained while out_ready stays high; each request passes the
// request register, then the result register, before out_valid rises. Bitmaps and used
// counts update at the same edge the result is registered, so the next request sees them
// at once.
// Synchronous active-low reset clears valids, bitmaps, counts and bases; sizes get reset values.
// A stalled result holds the request register; in_ready drops only when both are full.
module bitmap_slab_allocator
  import bsa_pkg::*;
#(
  parameter int SLOTS_PER_CACHE = SLOTS_PER_CACHE_DEF,
  parameter int NUM_CACHES      = NUM_CACHES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [SEL_W-1:0]       in_cache_sel,
  input  logic [ADDR_W-1:0]      in_free_address,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ADDR_W-1:0]      out_alloc_address,
  output logic                   out_success,
  output logic [CACHE_CNT_W-1:0] out_cache_used,
  output logic [CACHE_CNT_W-1:0] out_cache_free,
  output logic [TOTAL_CNT_W-1:0] out_total_used,
  output logic [TOTAL_CNT_W-1:0] out_total_free,
  output logic [BYTES_W-1:0]     out_used_bytes,
  output logic [BYTES_W-1:0]     out_free_bytes
);

  localparam int SLOT_W   = (SLOTS_PER_CACHE > 1) ? $clog2(SLOTS_PER_CACHE) : 1;
  localparam int CNT_W    = $clog2(SLOTS_PER_CACHE + 1);
  localparam int CACHE_W  = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;
  localparam int TOT_W    = $clog2(NUM_CACHES * SLOTS_PER_CACHE + 1);
  localparam int SUM_W    = CNT_W + 12 + CACHE_W + 1;
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS_PER_CACHE);
  localparam logic [TOT_W-1:0] SLOTS_TOT = TOT_W'(NUM_CACHES * SLOTS_PER_CACHE);

  // ---------------- configuration registers ----------------
  logic [ADDR_W-1:0] base_r [NUM_CACHES];
  logic [SIZE_W-1:0] size_r [NUM_CACHES];

  // Caches past the configurable ones keep their reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CACHES; c++) begin
        base_r[c] <= '0;
        size_r[c] <= size_reset(c);
      end
    end else if (cfg_wr_en) begin
      for (int c = 0; c < NUM_CACHES; c++) begin
        if (c < NUM_CFG_CACHES && cfg_index == CFG_BASE_FIRST + CFG_IDX_W'(c)) begin
          base_r[c] <= cfg_wdata[ADDR_W-1:0];
        end
        if (c < NUM_CFG_CACHES && cfg_index == CFG_SIZE_FIRST + CFG_IDX_W'(c)) begin
          size_r[c] <= cfg_wdata[SIZE_W-1:0];
        end
      end
    end
  end

  // ---------------- request register ----------------
  logic              s1_valid_r;
  logic [REQ_W-1:0]  s1_req_r;
  logic [SEL_W-1:0]  s1_sel_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              out_valid_r;
  logic              advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r  <= in_req_type;
      s1_sel_r  <= in_cache_sel;
      s1_addr_r <= in_free_address;
    end
  end

  // ---------------- allocator state ----------------
  logic [SLOTS_PER_CACHE-1:0] bitmap_r  [NUM_CACHES];
  logic [SLOTS_PER_CACHE-1:0] bitmap_nxt[NUM_CACHES];
  logic [CNT_W-1:0]           cnt_r     [NUM_CACHES];
  logic [CNT_W-1:0]           cnt_nxt   [NUM_CACHES];
  logic [SIZE_W-1:0]          eff_sz    [NUM_CACHES];
  logic [NUM_CACHES-1:0]      hit;

  // Cache select decode and effective object size
  always_comb begin
    for (int c = 0; c < NUM_CACHES; c++) begin
      hit[c]    = (32'(s1_sel_r) == 32'(c));
      eff_sz[c] = eff_size(size_r[c]);
    end
  end

  // Operand mux for the selected cache
  logic                       sel_ok;
  logic [SLOTS_PER_CACHE-1:0] sel_bm;
  logic [ADDR_W-1:0]          sel_base;
  logic [SIZE_W-1:0]          sel_sz;
  logic [CNT_W-1:0]           sel_cnt;

  always_comb begin
    sel_bm   = '0;
    sel_base = '0;
    sel_sz   = '0;
    sel_cnt  = '0;
    for (int c = 0; c < NUM_CACHES; c++) begin
      if (hit[c]) begin
        sel_bm   = bitmap_r[c];
        sel_base = base_r[c];
        sel_sz   = eff_sz[c];
        sel_cnt  = cnt_r[c];
      end
    end
  end

  assign sel_ok = |hit;

  // Lowest free slot of the selected cache
  logic              lf_found;
  logic [SLOT_W-1:0] lf_index;

  bsa_lowest_free #(
    .SLOTS_PER_CACHE (SLOTS_PER_CACHE),
    .SLOT_W          (SLOT_W)
  ) u_lowest_free (
    .avail_bits (~sel_bm),
    .found      (lf_found),
    .index      (lf_index)
  );

  // Free address to slot index
  logic [ADDR_W-1:0] free_off;
  logic [ADDR_W-1:0] free_shift;
  logic              free_ok;
  logic [SLOT_W-1:0] free_idx;
  logic              free_was_used;

  assign free_off      = s1_addr_r - sel_base;
  assign free_shift    = free_off >> sel_sz;
  assign free_ok       = (s1_addr_r >= sel_base) && (free_shift < ADDR_W'(SLOTS_PER_CACHE));
  assign free_idx      = free_shift[SLOT_W-1:0];
  assign free_was_used = free_ok && sel_bm[free_idx];

  // Request decode: new bitmap and count for the selected cache
  logic                       res_success;
  logic [ADDR_W-1:0]          res_addr;
  logic [SLOTS_PER_CACHE-1:0] new_bm;
  logic [CNT_W-1:0]           new_cnt;

  always_comb begin
    res_success = 1'b0;
    res_addr    = '0;
    new_bm      = sel_bm;
    new_cnt     = sel_cnt;
    if (sel_ok) begin
      case (s1_req_r)
        REQ_ALLOC: begin
          if (lf_found) begin
            res_success = 1'b1;
            res_addr    = sel_base + (ADDR_W'(lf_index) << sel_sz);
            new_bm      = sel_bm | (SLOTS_PER_CACHE'(1) << lf_index);
            new_cnt     = sel_cnt + CNT_W'(1);
          end
        end
        REQ_FREE: begin
          if (free_ok) begin
            res_success = 1'b1;
            new_bm      = sel_bm & ~(SLOTS_PER_CACHE'(1) << free_idx);
            if (free_was_used) begin
              new_cnt = sel_cnt - CNT_W'(1);
            end
          end
        end
        REQ_QUERY: begin
          res_success = 1'b1;
        end
        default: begin
          res_success = 1'b0;
        end
      endcase
    end
  end

  // Next state per cache
  always_comb begin
    for (int c = 0; c < NUM_CACHES; c++) begin
      bitmap_nxt[c] = hit[c] ? new_bm  : bitmap_r[c];
      cnt_nxt[c]    = hit[c] ? new_cnt : cnt_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CACHES; c++) begin
        bitmap_r[c] <= '0;
        cnt_r[c]    <= '0;
      end
    end else if (advance) begin
      for (int c = 0; c < NUM_CACHES; c++) begin
        bitmap_r[c] <= bitmap_nxt[c];
        cnt_r[c]    <= cnt_nxt[c];
      end
    end
  end

  // Statistics taken after the request
  logic [TOT_W-1:0] tot_used;
  logic [SUM_W-1:0] used_sum;
  logic [SUM_W-1:0] free_sum;

  always_comb begin
    tot_used = '0;
    used_sum = '0;
    free_sum = '0;
    for (int c = 0; c < NUM_CACHES; c++) begin
      tot_used = tot_used + TOT_W'(cnt_nxt[c]);
      used_sum = used_sum + (SUM_W'(cnt_nxt[c]) << eff_sz[c]);
      free_sum = free_sum + (SUM_W'(SLOTS_CNT - cnt_nxt[c]) << eff_sz[c]);
    end
  end

  // ---------------- result register ----------------
  logic [ADDR_W-1:0]      alloc_addr_r;
  logic                   success_r;
  logic [CACHE_CNT_W-1:0] cache_used_r;
  logic [CACHE_CNT_W-1:0] cache_free_r;
  logic [TOTAL_CNT_W-1:0] total_used_r;
  logic [TOTAL_CNT_W-1:0] total_free_r;
  logic [BYTES_W-1:0]     used_bytes_r;
  logic [BYTES_W-1:0]     free_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      alloc_addr_r <= res_addr;
      success_r    <= res_success;
      cache_used_r <= sel_ok ? CACHE_CNT_W'(new_cnt) : '0;
      cache_free_r <= sel_ok ? CACHE_CNT_W'(SLOTS_CNT - new_cnt) : '0;
      total_used_r <= TOTAL_CNT_W'(tot_used);
      total_free_r <= TOTAL_CNT_W'(SLOTS_TOT - tot_used);
      used_bytes_r <= used_sum[BYTES_W-1:0];
      free_bytes_r <= free_sum[BYTES_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_alloc_address = alloc_addr_r;
  assign out_success       = success_r;
  assign out_cache_used    = cache_used_r;
  assign out_cache_free    = cache_free_r;
  assign out_total_used    = total_used_r;
  assign out_total_free    = total_free_r;
  assign out_used_bytes    = used_bytes_r;
  assign out_free_bytes    = free_bytes_r;

endmodule

// ===== bench/slab_report_checker.sv =====
// Checker for the bitmap slab allocator: tracks cache state, predicts each result, compares.
`timescale 1ns / 100ps
module slab_report_checker
  import bsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,

  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [SEL_W-1:0]       in_cache_sel,
  input  logic [ADDR_W-1:0]      in_free_address,

  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [ADDR_W-1:0]      out_alloc_address,
  input  logic                   out_success,
  input  logic [CACHE_CNT_W-1:0] out_cache_used,
  input  logic [CACHE_CNT_W-1:0] out_cache_free,
  input  logic [TOTAL_CNT_W-1:0] out_total_used,
  input  logic [TOTAL_CNT_W-1:0] out_total_free,
  input  logic [BYTES_W-1:0]     out_used_bytes,
  input  logic [BYTES_W-1:0]     out_free_bytes,

  output int                     fail_count,
  output int                     result_count,
  output int                     pending
);

  localparam int SLOTS  = SLOTS_PER_CACHE_DEF;
  localparam int CACHES = NUM_CACHES_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ADDR_W-1:0]      addr;
    logic                   ok;
    logic [CACHE_CNT_W-1:0] cache_used;
    logic [CACHE_CNT_W-1:0] cache_free;
    logic [TOTAL_CNT_W-1:0] total_used;
    logic [TOTAL_CNT_W-1:0] total_free;
    logic [BYTES_W-1:0]     used_bytes;
    logic [BYTES_W-1:0]     free_bytes;
  } slab_report_t;

  // Shadow copy of the block's state and registers
  logic [SLOTS-1:0]  occupancy [CACHES];
  logic [ADDR_W-1:0] base_addr [CACHES];
  logic [SIZE_W-1:0] size_reg  [CACHES];

  slab_report_t slab_reports [$];
  int mismatches;
  int results;

  // Apply one request to the shadow state and work out the report it yields
  task automatic predict_outcome(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel,
                                 input logic [ADDR_W-1:0] addr, output slab_report_t r);
    logic [SLOTS-1:0]  word;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] slot_off;
    int sh, slot, used, tu, tf, ub, fb;
    r = '0;
    if (sel < CACHES) begin
      word = occupancy[sel];
      sh = (size_reg[sel] > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : size_reg[sel];
      case (req)
        REQ_ALLOC: begin
          // lowest clear bit wins; nothing happens when the cache is full
          if (!(&word)) begin
            slot = 0;
            while (word[slot]) slot++;
            occupancy[sel][slot] = 1'b1;
            slot_off = slot;
            r.addr = base_addr[sel] + (slot_off << sh);
            r.ok = 1'b1;
          end
        end
        REQ_FREE: begin
          if (addr >= base_addr[sel]) begin
            offset = (addr - base_addr[sel]) >> sh;
            if (offset < SLOTS) begin
              occupancy[sel][offset] = 1'b0;
              r.ok = 1'b1;
            end
          end
        end
        REQ_QUERY: r.ok = 1'b1;
        default: ;
      endcase
      used = $countones(occupancy[sel]);
      r.cache_used = CACHE_CNT_W'(used);
      r.cache_free = CACHE_CNT_W'(SLOTS - used);
    end

    // totals over every cache, taken after the request
    tu = 0; tf = 0; ub = 0; fb = 0;
    for (int c = 0; c < CACHES; c++) begin
      used = $countones(occupancy[c]);
      sh = (size_reg[c] > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : size_reg[c];
      tu += used;
      tf += SLOTS - used;
      ub += used << sh;
      fb += (SLOTS - used) << sh;
    end
    r.total_used = TOTAL_CNT_W'(tu);
    r.total_free = TOTAL_CNT_W'(tf);
    r.used_bytes = BYTES_W'(ub);
    r.free_bytes = BYTES_W'(fb);
  endtask

  task automatic flag_field(input string field, input logic [ADDR_W-1:0] want,
                            input logic [ADDR_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    slab_report_t want;
    slab_report_t seen;
    if (!rst_n) begin
      for (int c = 0; c < CACHES; c++) begin
        occupancy[c] = '0;
        base_addr[c] = '0;
        size_reg[c]  = '0;
      end
      size_reg[0] = SIZE_RESET_SMALL;
      size_reg[1] = SIZE_RESET_MEDIUM;
      size_reg[2] = SIZE_RESET_LARGE;
      slab_reports.delete();
      mismatches = 0;
      results = 0;
    end else begin
      // result side: compare against the oldest prediction
      if (out_valid && out_ready) begin
        results++;
        seen = {out_alloc_address, out_success, out_cache_used, out_cache_free,
                out_total_used, out_total_free, out_used_bytes, out_free_bytes};
        if (slab_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with no request outstanding, address %0h", $time,
                     out_alloc_address);
        end else begin
          want = slab_reports.pop_front();
          if (seen.addr !== want.addr) flag_field("alloc_address", want.addr, seen.addr);
          if (seen.ok !== want.ok) flag_field("success", want.ok, seen.ok);
          if (seen.cache_used !== want.cache_used)
            flag_field("cache_used", want.cache_used, seen.cache_used);
          if (seen.cache_free !== want.cache_free)
            flag_field("cache_free", want.cache_free, seen.cache_free);
          if (seen.total_used !== want.total_used)
            flag_field("total_used", want.total_used, seen.total_used);
          if (seen.total_free !== want.total_free)
            flag_field("total_free", want.total_free, seen.total_free);
          if (seen.used_bytes !== want.used_bytes)
            flag_field("used_bytes", want.used_bytes, seen.used_bytes);
          if (seen.free_bytes !== want.free_bytes)
            flag_field("free_bytes", want.free_bytes, seen.free_bytes);
        end
      end

      // request side
      if (in_valid && in_ready) begin
        predict_outcome(in_req_type, in_cache_sel, in_free_address, want);
        slab_reports.push_back(want);
      end

      // register writes; indexes past the size registers fall through
      if (cfg_wr_en) begin
        if (cfg_index >= CFG_BASE_FIRST && cfg_index < CFG_BASE_FIRST + NUM_CFG_CACHES)
          base_addr[cfg_index - CFG_BASE_FIRST] = cfg_wdata;
        else if (cfg_index >= CFG_SIZE_FIRST && cfg_index < CFG_SIZE_FIRST + NUM_CFG_CACHES)
          size_reg[cfg_index - CFG_SIZE_FIRST] = cfg_wdata[SIZE_W-1:0];
      end
    end
    fail_count   <= mismatches;
    result_count <= results;
    pending      <= slab_reports.size();
  end

endmodule

// ===== bench/bitmap_slab_allocator_test.sv =====
// Testbench top for the bitmap slab allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module bitmap_slab_allocator_test;
  import bsa_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int SLOTS        = SLOTS_PER_CACHE_DEF;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 240;
  localparam int STRETCH      = 80;
  localparam int GAP_PCT      = 32;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int TAIL_CYCLES  = 6;
  localparam int NO_STALL     = -1;

  localparam logic [REQ_W-1:0]     REQ_UNKNOWN   = 2'd3;
  localparam logic [SEL_W-1:0]     SEL_SMALL     = 2'd0;
  localparam logic [SEL_W-1:0]     SEL_MEDIUM    = 2'd1;
  localparam logic [SEL_W-1:0]     SEL_LARGE     = 2'd2;
  localparam logic [SEL_W-1:0]     SEL_UNKNOWN   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
  localparam int                   SPARE_REGS    = 2;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [REQ_W-1:0]       in_req_type = REQ_QUERY;
  logic [SEL_W-1:0]       in_cache_sel = SEL_SMALL;
  logic [ADDR_W-1:0]      in_free_address = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [ADDR_W-1:0]      out_alloc_address;
  logic                   out_success;
  logic [CACHE_CNT_W-1:0] out_cache_used;
  logic [CACHE_CNT_W-1:0] out_cache_free;
  logic [TOTAL_CNT_W-1:0] out_total_used;
  logic [TOTAL_CNT_W-1:0] out_total_free;
  logic [BYTES_W-1:0]     out_used_bytes;
  logic [BYTES_W-1:0]     out_free_bytes;

  int fail_count;
  int result_count;
  int pending;

  // Stimulus bookkeeping
  logic [ADDR_W-1:0] cur_base [NUM_CFG_CACHES];
  logic [SIZE_W-1:0] cur_size [NUM_CFG_CACHES];
  bit no_gaps = 1'b0;
  int stall_asks = 0;
  int stall_served = 0;
  int sent = 0;
  int layouts = 0;

  bitmap_slab_allocator u_top (.*);

  slab_report_checker u_checker (.*);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("timeout with %0d of %0d results in", result_count, sent);
    $display("bitmap_slab_allocator_test: errors");
    $finish;
  end

  // Result side: random back-pressure, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_served < stall_asks) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        stall_served++;
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic issue(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel,
                       input logic [ADDR_W-1:0] addr);
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_cache_sel    <= sel;
    in_free_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Stop offering until every outstanding result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_count < sent);
  endtask

  // Write all cache registers, then the unused indexes with junk
  task automatic load_layout(input logic [ADDR_W-1:0] b_s, b_m, b_l,
                             input logic [SIZE_W-1:0] z_s, z_m, z_l);
    logic [ADDR_W-1:0]     bases [NUM_CFG_CACHES];
    logic [SIZE_W-1:0]     sizes [NUM_CFG_CACHES];
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    bases[0] = b_s; bases[1] = b_m; bases[2] = b_l;
    sizes[0] = z_s; sizes[1] = z_m; sizes[2] = z_l;
    for (int i = 0; i < 2 * NUM_CFG_CACHES + SPARE_REGS; i++) begin
      data = $urandom;
      if (i < NUM_CFG_CACHES) begin
        idx  = CFG_IDX_W'(CFG_BASE_FIRST + i);
        data = bases[i];
      end else if (i < 2 * NUM_CFG_CACHES) begin
        idx  = CFG_IDX_W'(CFG_SIZE_FIRST + i - NUM_CFG_CACHES);
        data[SIZE_W-1:0] = sizes[i - NUM_CFG_CACHES];
      end else begin
        idx = CFG_IDX_W'(CFG_IDX_SPARE + i - 2 * NUM_CFG_CACHES);
      end
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= data;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    for (int c = 0; c < NUM_CFG_CACHES; c++) begin
      cur_base[c] = bases[c];
      cur_size[c] = sizes[c];
    end
    layouts++;
  endtask

  // Random traffic: alternating fill and drain stretches around one favored cache
  task automatic run_phase(input int items, input bit gapless, input int stall_at);
    int alloc_pct, k, sh;
    logic [SEL_W-1:0]  favored, sel;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr, slot_off;
    alloc_pct = 0;
    favored = SEL_SMALL;
    no_gaps = gapless;
    for (int n = 0; n < items; n++) begin
      if (n % STRETCH == 0) begin
        alloc_pct = (n % (2 * STRETCH) == 0) ? 75 : 20;
        favored = SEL_W'($urandom_range(SEL_LARGE));
      end
      if (n == stall_at) stall_asks++;
      sel  = ($urandom_range(99) < 70) ? favored : SEL_W'($urandom_range(SEL_LARGE));
      addr = $urandom;
      sh   = (cur_size[sel] > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : cur_size[sel];
      if ($urandom_range(99) < alloc_pct) begin
        req = REQ_ALLOC;
        if ($urandom_range(99) < 3) sel = SEL_UNKNOWN;
      end else begin
        k = $urandom_range(99);
        req = REQ_FREE;
        if (k < 60) begin
          // somewhere inside a real slot
          slot_off = $urandom_range(SLOTS - 1);
          addr = cur_base[sel] + (slot_off << sh) + (addr & ((32'd1 << sh) - 1));
        end else if (k < 72) begin
          sel = SEL_W'($urandom_range(SEL_UNKNOWN));
        end else if (k < 80) begin
          // just under the base or just past the last slot
          slot_off = SLOTS;
          addr = $urandom_range(1) ? cur_base[sel] - 1 - addr[3:0]
                                   : cur_base[sel] + (slot_off << sh) + addr[3:0];
        end else if (k < 90) begin
          req = REQ_QUERY;
          sel = SEL_W'($urandom_range(SEL_UNKNOWN));
        end else begin
          req = REQ_UNKNOWN;
          sel = SEL_W'($urandom_range(SEL_UNKNOWN));
        end
      end
      issue(req, sel, addr);
    end
    settle();
  endtask

  initial begin
    for (int c = 0; c < NUM_CFG_CACHES; c++) cur_base[c] = '0;
    cur_size[0] = SIZE_RESET_SMALL;
    cur_size[1] = SIZE_RESET_MEDIUM;
    cur_size[2] = SIZE_RESET_LARGE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset layout
    issue(REQ_QUERY, SEL_SMALL, '0);
    issue(REQ_ALLOC, SEL_SMALL, '0);
    issue(REQ_ALLOC, SEL_MEDIUM, '1);
    issue(REQ_ALLOC, SEL_LARGE, '0);
    settle();

    // Layout with two bases near the top of memory and a saturated object size
    load_layout(32'hFFFF_FFC0, 32'h0000_1000, 32'hFFFF_F000, 4'd15, 4'd0, 4'd12);
    issue(REQ_QUERY, SEL_SMALL, '0);
    issue(REQ_ALLOC, SEL_SMALL, '0);
    issue(REQ_ALLOC, SEL_SMALL, '0);             // wraps past 2^32
    issue(REQ_ALLOC, SEL_MEDIUM, '0);
    issue(REQ_ALLOC, SEL_LARGE, '0);
    issue(REQ_ALLOC, SEL_LARGE, '0);             // wraps to zero
    issue(REQ_FREE, SEL_SMALL, '0);              // under the base
    issue(REQ_FREE, SEL_SMALL, 32'hFFFF_FFC5);   // inside slot zero
    issue(REQ_FREE, SEL_SMALL, 32'hFFFF_FFC0);   // slot already free
    issue(REQ_FREE, SEL_MEDIUM, 32'h0000_1020);  // one past the last slot
    issue(REQ_FREE, SEL_MEDIUM, 32'h0000_101F);  // last slot, free already
    issue(REQ_FREE, SEL_MEDIUM, '1);
    issue(REQ_FREE, SEL_LARGE, '1);              // top of slot zero
    issue(REQ_ALLOC, SEL_UNKNOWN, '0);
    issue(REQ_QUERY, SEL_UNKNOWN, '1);
    issue(REQ_FREE, SEL_UNKNOWN, '0);
    issue(REQ_UNKNOWN, SEL_SMALL, '0);
    issue(REQ_UNKNOWN, SEL_UNKNOWN, '1);
    issue(REQ_FREE, SEL_SMALL, 32'h0000_0FC0);   // wrapped address sits under the base
    issue(REQ_ALLOC, SEL_MEDIUM, '1);
    issue(REQ_QUERY, SEL_LARGE, '1);
    settle();

    // Random phases over a spread of layouts
    load_layout('0, '0, '0, 4'd0, 4'd0, 4'd0);
    run_phase(PHASE_ITEMS, 1'b0, NO_STALL);
    load_layout('1, '1, '1, 4'd12, 4'd12, 4'd12);
    run_phase(PHASE_ITEMS, 1'b0, 100);
    load_layout($urandom, $urandom, $urandom, 4'd13, 4'd14, 4'd15);
    run_phase(PHASE_ITEMS, 1'b1, NO_STALL);
    load_layout($urandom, $urandom, $urandom, SIZE_W'($urandom_range(15)),
                SIZE_W'($urandom_range(15)), SIZE_W'($urandom_range(15)));
    run_phase(PHASE_ITEMS, 1'b0, 60);
    load_layout($urandom_range(32'hFFFF), $urandom_range(32'hFFFF), $urandom_range(32'hFFFF),
                SIZE_RESET_SMALL, SIZE_RESET_MEDIUM, SIZE_RESET_LARGE);
    run_phase(PHASE_ITEMS, 1'b0, NO_STALL);
    load_layout($urandom, $urandom, $urandom, 4'd15, 4'd0, 4'd12);
    run_phase(PHASE_ITEMS, 1'b0, NO_STALL);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests over %0d cache layouts, %0d results checked, %0d mismatches",
             sent, layouts, result_count, fail_count);
    if (pending != 0) $display("%0d predicted results never came out", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("bitmap_slab_allocator_test: clean");
    end else begin
      $display("bitmap_slab_allocator_test: errors");
    end
    $finish;
  end

endmodule
